// File: design/tage_pkg.sv
`timescale 1ns / 1ps
// Shared sizes, types and command/status bundles for the TAGE predictor.
// No dependencies; imported by the controller, the datapath and the top level.
package tage_pkg;

  localparam int TABLE_COUNT      = 8;
  localparam int BIM_ENTRIES      = 4096;
  localparam int TAGGED_ENTRIES   = 1024;
  localparam int TAG_BITS         = 9;
  localparam int SHORTEST_HISTORY = 2;
  localparam int LONGEST_HISTORY  = 256;

  localparam int HIST_BITS = ((LONGEST_HISTORY + 63) / 64) * 64;
  localparam int BIM_AW    = $clog2(BIM_ENTRIES);
  localparam int TAG_AW    = $clog2(TAGGED_ENTRIES);
  localparam int CLR_LEN   = (BIM_ENTRIES > TAGGED_ENTRIES) ? BIM_ENTRIES : TAGGED_ENTRIES;
  localparam int CNT_W     = $clog2(CLR_LEN);

  localparam logic [15:0] LFSR_SEED  = 16'hACE1;
  localparam logic [15:0] LFSR_MASK  = 16'hB400;
  localparam logic [15:0] PICK_LIMIT = 16'd21845;
  localparam logic [3:0]  TRUST_INIT = 4'd15;
  localparam logic [2:0]  CTR_INIT   = 3'd4;
  localparam logic [1:0]  BIM_INIT   = 2'd2;

  function automatic int fold_width_f();
    int w;
    w = 0;
    while ((2 << w) <= TAGGED_ENTRIES) w++;
    return w;
  endfunction

  localparam int FOLD_W     = fold_width_f();
  localparam int MAX_CHUNKS = LONGEST_HISTORY / FOLD_W;

  // geometric history length of tagged table i
  function automatic int hist_len(int i);
    int a;
    int best;
    int v;
    int k;
    bit stop;
    best = 0;
    stop = 1'b0;
    for (a = 1; a <= LONGEST_HISTORY; a++) begin
      if (!stop) begin
        v = SHORTEST_HISTORY;
        for (k = 0; k < TABLE_COUNT - 2; k++)
          if (v <= LONGEST_HISTORY) v = v * a;
        if (v <= LONGEST_HISTORY) best = a;
        else stop = 1'b1;
      end
    end
    if (i == 0) return 0;
    if (i == TABLE_COUNT - 1) return LONGEST_HISTORY;
    v = SHORTEST_HISTORY;
    for (k = 1; k < i; k++) v = v * best;
    return v;
  endfunction

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [2:0]          ctr;
  } tent_t;

  typedef struct packed {
    logic accept;
    logic eval;
    logic clr;
    logic age_rd;
    logic age_wr;
  } tage_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic age_last;
    logic age_req;
  } tage_stat_t;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_EVAL   = 5'b00100,
    ST_AGE_RD = 5'b01000,
    ST_AGE_WR = 5'b10000
  } tage_state_t;

endpackage

// File: design/tage_branch_predictor_top.sv
`timescale 1ns / 1ps
// Top level of the TAGE branch direction predictor.
// Depends on tage_pkg, tage_ctrl and tage_dp.
//
//  channel   handshake        payload                                      
//  input     start & !busy    pc[31:0], taken                              
//  result    done (1 cycle)   predicted_taken, provider_table[3:0],        
//                             used_alternate, mispredicted                 
//
// All tables are read at the transfer edge of an item; the next
// cycle evaluates, writes back and registers the result.
// After reset a clearing pass over the bimodal table depth (4096 entries) holds busy.
// Every 2^18 updates a useful-bit aging sweep holds busy while it reads and writes
// each of the 1024 rows. The receiver cannot stall.
module tage_branch_predictor_top
  import tage_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] pc,
  input  logic        taken,
  output logic        done,
  output logic        predicted_taken,
  output logic [3:0]  provider_table,
  output logic        used_alternate,
  output logic        mispredicted
);

  tage_cmd_t  cmd;
  tage_stat_t stat;

  tage_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  tage_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .pc              (pc),
    .taken           (taken),
    .done            (done),
    .predicted_taken (predicted_taken),
    .provider_table  (provider_table),
    .used_alternate  (used_alternate),
    .mispredicted    (mispredicted)
  );

endmodule

// File: design/tage_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the TAGE predictor: clear pass, lookup/update, useful aging sweep.
// Depends on tage_pkg.
module tage_ctrl
  import tage_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  tage_stat_t stat,
  output tage_cmd_t  cmd,
  output logic       busy
);

  tage_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (stat.clr_last) state_next = ST_IDLE;
      ST_IDLE:   if (start) state_next = ST_EVAL;
      ST_EVAL:   state_next = stat.age_req ? ST_AGE_RD : ST_IDLE;
      ST_AGE_RD: state_next = ST_AGE_WR;
      ST_AGE_WR: if (stat.age_last) state_next = ST_IDLE;
                 else state_next = ST_AGE_RD;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd.accept = (state == ST_IDLE) && start;
    cmd.eval   = (state == ST_EVAL);
    cmd.clr    = (state == ST_CLEAR);
    cmd.age_rd = (state == ST_AGE_RD);
    cmd.age_wr = (state == ST_AGE_WR);
    busy       = (state != ST_IDLE);
  end

endmodule

// File: design/tage_dp.sv
`timescale 1ns / 1ps
// Datapath for the TAGE predictor: tables, history, trust, LFSR, result registers.
// Depends on tage_pkg; driven by tage_ctrl commands.
module tage_dp
  import tage_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  tage_cmd_t   cmd,
  output tage_stat_t  stat,
  input  logic [31:0] pc,
  input  logic        taken,
  output logic        done,
  output logic        predicted_taken,
  output logic [3:0]  provider_table,
  output logic        used_alternate,
  output logic        mispredicted
);

  localparam int NT = TABLE_COUNT;

  tent_t      ent_mem [1:NT-1][TAGGED_ENTRIES];
  logic [1:0] use_mem [1:NT-1][TAGGED_ENTRIES];
  logic [1:0] bim_mem [BIM_ENTRIES];

  tent_t       ent_rd [1:NT-1];
  logic [1:0]  use_rd [1:NT-1];
  logic [1:0]  bim_rd;

  logic [HIST_BITS-1:0] hist;
  logic [3:0]           trust;
  logic [18:0]          update_count;
  logic [15:0]          lfsr;
  logic [CNT_W-1:0]     cnt;
  logic [1:0]           age_keep;
  logic                 fix_valid;
  logic [3:0]           fix_tbl;
  logic [TAG_AW-1:0]    fix_idx;

  logic [31:0]        pc_q;
  logic               taken_q;
  logic [TAG_AW-1:0]  idx_q [1:NT-1];
  logic [BIM_AW-1:0]  bidx_q;

  logic [TAG_AW-1:0]  idx [1:NT-1];
  logic [FOLD_W-1:0]  fold [1:NT-1];

  // index = pc ^ folded history, per table
  always_comb begin
    logic [31:0] v;
    int chunks;
    int pos;
    for (int t = 1; t < NT; t++) begin
      chunks = hist_len(t) / FOLD_W;
      fold[t] = '0;
      for (int c = 0; c < MAX_CHUNKS; c++)
        for (int b = 0; b < FOLD_W; b++) begin
          pos = c * FOLD_W + b;
          if (c < chunks && pos < HIST_BITS) fold[t][b] = fold[t][b] ^ hist[pos];
        end
      v = (pc ^ 32'(fold[t])) & 32'(TAGGED_ENTRIES - 1);
      idx[t] = v[TAG_AW-1:0];
    end
  end

  // lookup and update decisions
  logic [3:0]  prov, alt, first, second, pick;
  logic        provpred, altpred, provnew, trust_hit, alt_used, pred, mis;
  logic [2:0]  p_ctr;
  logic [1:0]  p_use;
  logic        alloc_en, two, dec_all, train_bim, use_train, aging, lfsr_step;
  logic [18:0] count_next;
  logic [1:0]  keepm;
  logic [3:0]  trust_next;
  logic [1:0]  bim_next;
  tent_t       ent_wd [1:NT-1];
  logic [1:0]  use_wd [1:NT-1];

  always_comb begin
    logic tagpred;
    prov = '0; alt = '0; provpred = 1'b0; tagpred = 1'b0;
    p_ctr = '0; p_use = '0;
    for (int t = 1; t < NT; t++) begin
      if (ent_rd[t].tag == pc_q[TAG_BITS-1:0]) begin
        alt     = prov;
        tagpred = provpred;
        prov    = 4'(t);
        provpred = ent_rd[t].ctr[2];
        p_ctr   = ent_rd[t].ctr;
        p_use   = use_rd[t];
      end
    end
    altpred   = (alt == 4'd0) ? bim_rd[1] : tagpred;
    provnew   = (prov != 4'd0) && (p_use == 2'd0) && (p_ctr == 3'd3 || p_ctr == 3'd4);
    trust_hit = (prov != 4'd0) && ((trust < 4'd8) || !provnew);
    alt_used  = !trust_hit;
    pred      = alt_used ? altpred : provpred;
    mis       = pred != taken_q;

    count_next = update_count + 19'd1;
    aging      = (count_next[17:0] == 18'd0);
    keepm      = !aging ? 2'b11 : (count_next[18] ? 2'b01 : 2'b10);

    trust_next = trust;
    if (provnew && altpred != provpred) begin
      if (altpred == taken_q) begin
        if (trust != 4'd15) trust_next = trust + 4'd1;
      end else if (trust != 4'd0) trust_next = trust - 4'd1;
    end

    first = '0; second = '0;
    for (int t = 1; t < NT; t++)
      if (4'(t) > prov && use_rd[t] == 2'd0) begin
        if (first == 4'd0) first = 4'(t);
        else if (second == 4'd0) second = 4'(t);
      end
    alloc_en  = mis && (prov < 4'(NT - 1));
    two       = second != 4'd0;
    pick      = (two && lfsr > PICK_LIMIT) ? second : first;
    lfsr_step = alloc_en && two;
    dec_all   = alloc_en && (first == 4'd0);

    train_bim = (prov == 4'd0) || (alt == 4'd0 && alt_used);
    use_train = (prov != 4'd0) && (provpred != altpred);

    bim_next = bim_rd;
    if (taken_q) begin
      if (bim_rd != 2'd3) bim_next = bim_rd + 2'd1;
    end else if (bim_rd != 2'd0) bim_next = bim_rd - 2'd1;

    for (int t = 1; t < NT; t++) begin
      ent_wd[t] = ent_rd[t];
      use_wd[t] = use_rd[t];
      if (dec_all && 4'(t) > prov && use_rd[t] != 2'd0) use_wd[t] = use_rd[t] - 2'd1;
      use_wd[t] = use_wd[t] & keepm;
      if (4'(t) == prov) begin
        if (!train_bim) begin
          if (taken_q) begin
            if (ent_rd[t].ctr != 3'd7) ent_wd[t].ctr = ent_rd[t].ctr + 3'd1;
          end else if (ent_rd[t].ctr != 3'd0) ent_wd[t].ctr = ent_rd[t].ctr - 3'd1;
        end
        if (use_train) begin
          if (provpred == taken_q) begin
            if (use_wd[t] != 2'd3) use_wd[t] = use_wd[t] + 2'd1;
          end else if (use_wd[t] != 2'd0) use_wd[t] = use_wd[t] - 2'd1;
        end
      end
      // new entry: weak counter on the side of the outcome
      if (alloc_en && first != 4'd0 && 4'(t) == pick) begin
        ent_wd[t].tag = pc_q[TAG_BITS-1:0];
        ent_wd[t].ctr = 3'd3 + {2'b00, taken_q};
        use_wd[t] = 2'd0;
      end
    end
  end

  assign stat.clr_last = (cnt == CNT_W'(CLR_LEN - 1));
  assign stat.age_last = (cnt[TAG_AW-1:0] == TAG_AW'(TAGGED_ENTRIES - 1));
  assign stat.age_req  = aging;

  // table ports
  always_ff @(posedge clk) begin
    for (int t = 1; t < NT; t++) begin
      if (cmd.clr) begin
        ent_mem[t][cnt[TAG_AW-1:0]] <= '{tag: '0, ctr: CTR_INIT};
        use_mem[t][cnt[TAG_AW-1:0]] <= 2'd0;
      end else if (cmd.eval) begin
        ent_mem[t][idx_q[t]] <= ent_wd[t];
        use_mem[t][idx_q[t]] <= use_wd[t];
      end else if (cmd.age_wr &&
                   !(fix_valid && fix_tbl == 4'(t) && fix_idx == cnt[TAG_AW-1:0])) begin
        use_mem[t][cnt[TAG_AW-1:0]] <= use_rd[t] & age_keep;
      end
      ent_rd[t] <= ent_mem[t][cmd.accept ? idx[t] : cnt[TAG_AW-1:0]];
      use_rd[t] <= use_mem[t][cmd.accept ? idx[t] : cnt[TAG_AW-1:0]];
    end
    if (cmd.clr) bim_mem[cnt[BIM_AW-1:0]] <= BIM_INIT;
    else if (cmd.eval && train_bim) bim_mem[bidx_q] <= bim_next;
    bim_rd <= bim_mem[pc[BIM_AW-1:0]];
  end

  // item capture and outputs
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pc_q    <= pc;
      taken_q <= taken;
      bidx_q  <= pc[BIM_AW-1:0];
      for (int t = 1; t < NT; t++) idx_q[t] <= idx[t];
    end
    if (cmd.eval) begin
      predicted_taken <= pred;
      provider_table  <= prov;
      used_alternate  <= alt_used;
      mispredicted    <= mis;
      age_keep        <= keepm;
      fix_tbl         <= prov;
      fix_idx         <= idx_q[prov[$clog2(NT)-1:0]];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      hist         <= '0;
      trust        <= TRUST_INIT;
      update_count <= '0;
      lfsr         <= LFSR_SEED;
      cnt          <= '0;
      done         <= 1'b0;
      fix_valid    <= 1'b0;
    end else begin
      done <= cmd.eval;
      if (cmd.eval) begin
        hist         <= {hist[HIST_BITS-2:0], taken_q};
        trust        <= trust_next;
        update_count <= count_next;
        fix_valid    <= aging && (prov != 4'd0);
        if (lfsr_step) lfsr <= {1'b0, lfsr[15:1]} ^ (lfsr[0] ? LFSR_MASK : 16'd0);
      end
      if (cmd.clr) cnt <= stat.clr_last ? '0 : cnt + CNT_W'(1);
      else if (cmd.age_wr) cnt <= stat.age_last ? '0 : cnt + CNT_W'(1);
    end
  end

endmodule
